[hdl/md5_pkg.sv]
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, microcode layout and constant tables of the md5 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

   localparam int MD5_BLOCK_WORDS = 16;
   localparam int UC_ADDR_W       = 7;

   // microcode addresses
   localparam logic [UC_ADDR_W-1:0] UC_WAIT     = 7'd0;
   localparam logic [UC_ADDR_W-1:0] UC_CHECK    = 7'd1;
   localparam logic [UC_ADDR_W-1:0] UC_MARK     = 7'd2;
   localparam logic [UC_ADDR_W-1:0] UC_FILL     = 7'd3;
   localparam logic [UC_ADDR_W-1:0] UC_LEN_LO   = 7'd4;
   localparam logic [UC_ADDR_W-1:0] UC_LEN_HI   = 7'd5;
   localparam logic [UC_ADDR_W-1:0] UC_DIGEST   = 7'd6;
   localparam logic [UC_ADDR_W-1:0] UC_RESTART  = 7'd7;
   localparam logic [UC_ADDR_W-1:0] UC_COMPRESS = 7'd8;
   localparam logic [UC_ADDR_W-1:0] UC_ROUND0   = 7'd9;
   localparam logic [UC_ADDR_W-1:0] UC_ROUND63  = 7'd72;
   localparam logic [UC_ADDR_W-1:0] UC_FOLD     = 7'd73;

   localparam logic [31:0] MD5_CHAIN_SEED [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };
   localparam logic [7:0] MD5_MARK = 8'h80;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } md5_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        digest_last;
   } md5_rsp_type;

   typedef enum logic [2:0] {
      PUSH_NONE, PUSH_DATA, PUSH_MARK, PUSH_ZERO, PUSH_LEN_LO, PUSH_LEN_HI
   } md5_push_type;

   typedef enum logic [1:0] {
      GATE_ALWAYS, GATE_COND, GATE_NCOND, GATE_ACCEPT
   } md5_gate_type;

   typedef enum logic [2:0] {
      COND_NONE, COND_ALWAYS, COND_WAIT_WORD, COND_PARTIAL, COND_POS_NOT_END,
      COND_OUT_BUSY
   } md5_cond_type;

   typedef enum logic [1:0] {
      FUNC_F, FUNC_G, FUNC_H, FUNC_I
   } md5_func_type;

   typedef struct packed {
      logic                 ready;
      md5_push_type         push;
      md5_gate_type         gate;
      md5_cond_type         cond;
      logic [UC_ADDR_W-1:0] target;
      logic                 ret;
      logic                 load;
      logic                 round;
      md5_func_type         func;
      logic [4:0]           rot;
      logic [5:0]           kidx;
      logic [3:0]           rd_addr;
      logic                 fold;
      logic                 digest;
   } md5_ucode_type;

   // sequencer to datapath, with actions already gated
   typedef struct packed {
      logic         ready;
      md5_push_type push;
      logic         load;
      logic         round;
      md5_func_type func;
      logic [4:0]   rot;
      logic [5:0]   kidx;
      logic [3:0]   rd_addr;
      logic         fold;
      logic         digest;
   } md5_ctrl_type;

   typedef struct packed {
      logic partial;
      logic pos_end;
      logic block_end;
      logic out_busy;
   } md5_status_type;

   function automatic logic [3:0] md5_msg_index(input logic [5:0] i);
      logic [3:0] r;
      logic [3:0] g;
      r = i[3:0];
      case (i[5:4])
         2'd0:    g = r;
         2'd1:    g = 4'(r * 4'd5 + 4'd1);
         2'd2:    g = 4'(r * 4'd3 + 4'd5);
         default: g = 4'(r * 4'd7);
      endcase
      return g;
   endfunction

   function automatic logic [4:0] md5_rot_amount(input logic [3:0] idx);
      logic [4:0] s;
      case (idx)
         4'd0:    s = 5'd7;
         4'd1:    s = 5'd12;
         4'd2:    s = 5'd17;
         4'd3:    s = 5'd22;
         4'd4:    s = 5'd5;
         4'd5:    s = 5'd9;
         4'd6:    s = 5'd14;
         4'd7:    s = 5'd20;
         4'd8:    s = 5'd4;
         4'd9:    s = 5'd11;
         4'd10:   s = 5'd16;
         4'd11:   s = 5'd23;
         4'd12:   s = 5'd6;
         4'd13:   s = 5'd10;
         4'd14:   s = 5'd15;
         default: s = 5'd21;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] md5_round_const(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   // control store: message intake and padding, then the compression routine
   function automatic md5_ucode_type md5_ucode(input logic [UC_ADDR_W-1:0] addr);
      md5_ucode_type uc;
      logic [5:0]    ri;
      uc        = '0;
      uc.push   = PUSH_NONE;
      uc.gate   = GATE_ALWAYS;
      uc.cond   = COND_NONE;
      uc.func   = FUNC_F;
      ri        = 6'(addr - UC_ROUND0);
      if (addr inside {[UC_ROUND0:UC_ROUND63]}) begin
         uc.round   = 1'b1;
         uc.func    = md5_func_type'(ri[5:4]);
         uc.rot     = md5_rot_amount({ri[5:4], ri[1:0]});
         uc.kidx    = ri;
         uc.rd_addr = md5_msg_index(6'(ri + 6'd1));
      end else begin
         case (addr)
            UC_WAIT: begin
               uc.ready  = 1'b1;
               uc.push   = PUSH_DATA;
               uc.gate   = GATE_ACCEPT;
               uc.cond   = COND_WAIT_WORD;
               uc.target = UC_WAIT;
            end
            UC_CHECK: begin
               uc.cond   = COND_PARTIAL;
               uc.target = UC_FILL;
            end
            UC_MARK: begin
               uc.push = PUSH_MARK;
            end
            UC_FILL: begin
               uc.push   = PUSH_ZERO;
               uc.gate   = GATE_COND;
               uc.cond   = COND_POS_NOT_END;
               uc.target = UC_FILL;
            end
            UC_LEN_LO: begin
               uc.push = PUSH_LEN_LO;
            end
            UC_LEN_HI: begin
               uc.push = PUSH_LEN_HI;
            end
            UC_DIGEST: begin
               uc.digest = 1'b1;
               uc.gate   = GATE_NCOND;
               uc.cond   = COND_OUT_BUSY;
               uc.target = UC_DIGEST;
            end
            UC_RESTART: begin
               uc.cond   = COND_ALWAYS;
               uc.target = UC_WAIT;
            end
            UC_COMPRESS: begin
               uc.load    = 1'b1;
               uc.rd_addr = md5_msg_index(6'd0);
            end
            UC_FOLD: begin
               uc.fold = 1'b1;
               uc.ret  = 1'b1;
            end
            default: begin
               uc.cond   = COND_ALWAYS;
               uc.target = UC_WAIT;
            end
         endcase
      end
      return uc;
   endfunction

endpackage

`default_nettype wire

[hdl/md5_chan_if.sv]
// ----------------------------------------------------------------------------
// md5_chan_if
// Valid/ready stream channel carrying one payload struct per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface md5_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/md5_sequencer.sv]
// ----------------------------------------------------------------------------
// md5_sequencer
// Step counter over the control store, with conditional jumps and a one-level
// call into the compression routine whenever a push completes a block.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last,
   input  wire md5_pkg::md5_status_type status,
   output md5_pkg::md5_ctrl_type        ctrl
);
   import md5_pkg::*;

   logic [UC_ADDR_W-1:0] pc_ff, pc_in;
   logic [UC_ADDR_W-1:0] ret_ff, ret_in;
   logic [UC_ADDR_W-1:0] base;
   md5_ucode_type        uc;
   logic                 accept;
   logic                 cond_true;
   logic                 act;
   logic                 push_fire;

   always_comb begin
      uc     = md5_ucode(pc_ff);
      accept = uc.ready & req_valid;

      case (uc.cond)
         COND_NONE:        cond_true = 1'b0;
         COND_ALWAYS:      cond_true = 1'b1;
         COND_WAIT_WORD:   cond_true = !(accept && req_last);
         COND_PARTIAL:     cond_true = status.partial;
         COND_POS_NOT_END: cond_true = !status.pos_end;
         COND_OUT_BUSY:    cond_true = status.out_busy;
         default:          cond_true = 1'b0;
      endcase

      case (uc.gate)
         GATE_ALWAYS: act = 1'b1;
         GATE_COND:   act = cond_true;
         GATE_NCOND:  act = !cond_true;
         GATE_ACCEPT: act = accept;
         default:     act = 1'b0;
      endcase

      push_fire = act && (uc.push != PUSH_NONE);
      base      = cond_true ? uc.target : UC_ADDR_W'(pc_ff + 1'b1);
   end

   // next step
   always_comb begin
      ret_in = ret_ff;
      if (uc.ret) begin
         pc_in = ret_ff;
      end else if (push_fire && status.block_end) begin
         // block just filled: run the rounds, then carry on where we were
         pc_in  = UC_COMPRESS;
         ret_in = base;
      end else begin
         pc_in = base;
      end
   end

   // control to the datapath
   always_comb begin
      ctrl.ready   = uc.ready;
      ctrl.push    = push_fire ? uc.push : PUSH_NONE;
      ctrl.load    = uc.load;
      ctrl.round   = uc.round;
      ctrl.func    = uc.func;
      ctrl.rot     = uc.rot;
      ctrl.kidx    = uc.kidx;
      ctrl.rd_addr = uc.rd_addr;
      ctrl.fold    = uc.fold;
      ctrl.digest  = uc.digest & act;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= UC_WAIT;
         ret_ff <= UC_WAIT;
      end else begin
         pc_ff  <= pc_in;
         ret_ff <= ret_in;
      end
   end

endmodule

`default_nettype wire

[hdl/md5_datapath.sv]
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, word position, bit count, chaining words, the round unit and
// the digest holding register that feeds the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_datapath #(
   parameter int BLOCK_WORDS = md5_pkg::MD5_BLOCK_WORDS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire md5_pkg::md5_ctrl_type   ctrl,
   input  wire md5_pkg::md5_req_type    req_payload,
   input  wire logic                    rsp_take,
   output md5_pkg::md5_status_type      status,
   output logic                         rsp_valid,
   output md5_pkg::md5_rsp_type         rsp_payload
);
   import md5_pkg::*;

   localparam int POS_W = $clog2(BLOCK_WORDS);

   logic [31:0]      buf_mem [BLOCK_WORDS];
   logic [31:0]      rd_data_ff;
   logic [POS_W-1:0] wpos_ff, wpos_in;
   logic [63:0]      bitlen_ff, bitlen_in;
   logic             partial_ff, partial_in;
   logic [31:0]      chain_ff [4];
   logic [31:0]      chain_in [4];
   logic [31:0]      a_ff, b_ff, c_ff, d_ff;
   logic [31:0]      out_ff [4];
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_idx_ff, out_idx_in;

   logic [2:0]       cnt;
   logic [31:0]      last_word;
   logic [31:0]      push_word;
   logic [31:0]      f_val;
   logic [31:0]      sum;
   logic [63:0]      dbl;
   logic             push_en;

   // last word: keep the valid low bytes and, if fewer than four, place the marker above them
   always_comb begin
      cnt = (req_payload.byte_count > 3'd4) ? 3'd4 : req_payload.byte_count;
      case (cnt)
         3'd0:    last_word = {24'h0, MD5_MARK};
         3'd1:    last_word = {16'h0, MD5_MARK, req_payload.data_word[7:0]};
         3'd2:    last_word = {8'h0, MD5_MARK, req_payload.data_word[15:0]};
         3'd3:    last_word = {MD5_MARK, req_payload.data_word[23:0]};
         default: last_word = req_payload.data_word;
      endcase
   end

   always_comb begin
      push_en = (ctrl.push != PUSH_NONE);
      case (ctrl.push)
         PUSH_DATA:   push_word = req_payload.last ? last_word : req_payload.data_word;
         PUSH_MARK:   push_word = {24'h0, MD5_MARK};
         PUSH_LEN_LO: push_word = bitlen_ff[31:0];
         PUSH_LEN_HI: push_word = bitlen_ff[63:32];
         default:     push_word = 32'h0;
      endcase
   end

   // round unit
   always_comb begin
      case (ctrl.func)
         FUNC_F:  f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         FUNC_G:  f_val = (d_ff & b_ff) | (~d_ff & c_ff);
         FUNC_H:  f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f_val + md5_round_const(ctrl.kidx) + rd_data_ff;
      dbl = {sum, sum} << ctrl.rot;
   end

   // message state
   always_comb begin
      wpos_in    = wpos_ff;
      bitlen_in  = bitlen_ff;
      partial_in = partial_ff;
      for (int k = 0; k < 4; k++) begin
         chain_in[k] = chain_ff[k];
      end
      if (push_en) begin
         wpos_in = (wpos_ff == POS_W'(BLOCK_WORDS - 1)) ? '0 : POS_W'(wpos_ff + 1'b1);
      end
      if (ctrl.push == PUSH_DATA) begin
         bitlen_in = req_payload.last ? bitlen_ff + {58'h0, cnt, 3'b000}
                                      : bitlen_ff + 64'd32;
         if (req_payload.last) begin
            partial_in = (cnt != 3'd4);
         end
      end
      if (ctrl.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end
      if (ctrl.digest) begin
         wpos_in   = '0;
         bitlen_in = '0;
         for (int k = 0; k < 4; k++) begin
            chain_in[k] = MD5_CHAIN_SEED[k];
         end
      end
   end

   // digest holding register, drained one word per beat
   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      if (ctrl.digest) begin
         out_valid_in = 1'b1;
         out_idx_in   = 2'd0;
      end else if (rsp_take) begin
         if (out_idx_ff == 2'd3) begin
            out_valid_in = 1'b0;
         end
         out_idx_in = 2'(out_idx_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff      <= '0;
         bitlen_ff    <= '0;
         partial_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= 2'd0;
         for (int k = 0; k < 4; k++) begin
            chain_ff[k] <= MD5_CHAIN_SEED[k];
         end
      end else begin
         wpos_ff      <= wpos_in;
         bitlen_ff    <= bitlen_in;
         partial_ff   <= partial_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
         for (int k = 0; k < 4; k++) begin
            chain_ff[k] <= chain_in[k];
         end
      end
   end

   // block buffer: one write, one registered read a cycle
   always_ff @(posedge clock) begin
      if (push_en) begin
         buf_mem[wpos_ff] <= push_word;
      end
      rd_data_ff <= buf_mem[POS_W'(ctrl.rd_addr)];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
      end else if (ctrl.round) begin
         a_ff <= d_ff;
         b_ff <= b_ff + dbl[63:32];
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
      if (ctrl.digest) begin
         for (int k = 0; k < 4; k++) begin
            out_ff[k] <= chain_ff[k];
         end
      end
   end

   always_comb begin
      status.partial   = partial_ff;
      status.pos_end   = (wpos_ff == POS_W'(BLOCK_WORDS - 2));
      status.block_end = (wpos_ff == POS_W'(BLOCK_WORDS - 1));
      status.out_busy  = out_valid_ff;

      rsp_valid               = out_valid_ff;
      rsp_payload.digest_word = out_ff[out_idx_ff];
      rsp_payload.word_index  = out_idx_ff;
      rsp_payload.digest_last = (out_idx_ff == 2'd3);
   end

endmodule

`default_nettype wire

[hdl/md5_message_digest_top.sv]
// ----------------------------------------------------------------------------
// md5_message_digest_top
// MD5 digest engine driven by a microcoded sequencer over a round datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes the message one 32-bit little-endian word per beat, first
//   byte in bits 7:0. The word with last set carries 0 to 4 bytes (byte_count,
//   larger values count as 4); padding and the bit length are added inside.
//   rsp_chan then gives four beats, digest words A to D, digest_last on D.
//   Words are taken one per beat while ready; every sixteenth word starts a
//   compression (load, 64 rounds at one round per cycle, fold), during which
//   req_chan is not ready, so the round loop sets the throughput. After the
//   last word come the padding words and one or two compressions before
//   the first digest beat.
//   The digest sits in a holding register; a stalled receiver does not stop
//   the next message, which only waits if its digest is ready before the
//   previous one has drained. Reset returns the chaining words to the MD5
//   initial values, clears the word position and bit count, drops rsp valid.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_message_digest_top #(
   parameter int BLOCK_WORDS = md5_pkg::MD5_BLOCK_WORDS
) (
   input wire logic   clock,
   input wire logic   reset,
   md5_chan_if.sink   req_chan,
   md5_chan_if.source rsp_chan
);
   import md5_pkg::*;

   md5_ctrl_type   ctrl;
   md5_status_type status;
   md5_req_type    req_payload;
   md5_rsp_type    rsp_payload;
   logic           rsp_valid;
   logic           rsp_take;

   assign req_payload      = req_chan.payload;
   assign req_chan.ready   = ctrl.ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;
   assign rsp_take         = rsp_valid & rsp_chan.ready;

   md5_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_payload.last),
      .status    (status),
      .ctrl      (ctrl)
   );

   md5_datapath #(
      .BLOCK_WORDS (BLOCK_WORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_payload (req_payload),
      .rsp_take    (rsp_take),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // a new digest never overwrites one still draining
   assert property (@(posedge clock) disable iff (reset)
      ctrl.digest |-> !rsp_valid)
      else $error("digest loaded while result buffer busy");

   // pushes into the block buffer never overlap the round loop
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.push != PUSH_NONE) |-> !(ctrl.round || ctrl.load || ctrl.fold))
      else $error("buffer push during compression");

   // after the beat carrying D the result side goes quiet
   assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_payload.digest_last) |=> !rsp_valid)
      else $error("result valid after final digest beat");

   // an accepted word that completes a block is followed by the load step
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && ctrl.ready && status.block_end) |=> ctrl.load)
      else $error("full block not compressed");

endmodule

`default_nettype wire
